### rtl/core/double_ended_queue_defines.svh
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Concurrent checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset
`define DEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DEQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Sizes, opcodes, control structs and ring arithmetic for the deque.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int BYTE_W = 8;

	typedef enum logic [2:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_DUMP_FWD   = 3'd4,
		OP_DUMP_BWD   = 3'd5
	} deq_op_t;

	typedef struct packed {
		logic latch;
		logic exec;
		logic load_data;
		logic step;
	} deq_cmd_t;

	typedef struct packed {
		logic op_valid;
		logic is_push;
		logic empty;
		logic out_last;
	} deq_status_t;

	// (base + off) mod DEPTH, both operands below DEPTH
	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
			input logic [IDX_W-1:0] off);
		logic [IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (IDX_W+1)'(DEPTH)) begin
			sum = sum - (IDX_W+1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

### rtl/core/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/deq_dp.sv
// ----------------------------------------------------------------------------
// deq_dp
// Deque datapath: ring pointers, entry store, dump index and result word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_ended_queue_defines.svh"

module deq_dp import deq_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire deq_cmd_t          cmd,
	output deq_status_t            status,
	input  wire logic [2:0]        opcode,
	input  wire logic [BYTE_W-1:0] push_byte,
	output logic      [BYTE_W-1:0] out_byte,
	output logic                   is_empty,
	output logic                   overflow,
	output logic                   last_of_run
);

	logic [2:0]        op_q;
	logic [BYTE_W-1:0] byte_q;
	logic [IDX_W-1:0]  front_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  iter_q;

	logic              is_push, is_pop, is_dump, full, empty;
	logic [IDX_W-1:0]  front_dec, front_inc;
	logic [CNT_W-1:0]  count_m1;
	logic [IDX_W-1:0]  back_off;
	logic              we, re;
	logic [IDX_W-1:0]  waddr, raddr;
	logic [BYTE_W-1:0] rdata;

	assign is_push = (op_q == OP_PUSH_BACK) || (op_q == OP_PUSH_FRONT);
	assign is_pop  = (op_q == OP_POP_BACK) || (op_q == OP_POP_FRONT);
	assign is_dump = (op_q == OP_DUMP_FWD) || (op_q == OP_DUMP_BWD);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);

	assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign count_m1  = count_q - 1'b1;
	assign back_off  = count_m1[IDX_W-1:0] - iter_q;

	assign we    = cmd.exec && is_push && !full;
	assign waddr = (op_q == OP_PUSH_FRONT) ? front_dec
	                                       : ring_add(front_q, count_q[IDX_W-1:0]);
	assign re    = cmd.exec && (is_pop || is_dump) && !empty;

	always_comb begin
		unique case (op_q)
			OP_POP_BACK:  raddr = ring_add(front_q, count_m1[IDX_W-1:0]);
			OP_POP_FRONT: raddr = front_q;
			OP_DUMP_FWD:  raddr = ring_add(front_q, iter_q);
			OP_DUMP_BWD:  raddr = ring_add(front_q, back_off);
			default:      raddr = front_q;
		endcase
	end

	deq_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (byte_q),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// input word, held for the whole operation
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= opcode;
			byte_q <= push_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			iter_q  <= '0;
		end else begin
			if (we) begin
				count_q <= count_q + 1'b1;
				if (op_q == OP_PUSH_FRONT) begin
					front_q <= front_dec;
				end
			end else if (re && is_pop) begin
				count_q <= count_m1;
				if (op_q == OP_POP_FRONT) begin
					front_q <= front_inc;
				end
			end
			if (cmd.latch) begin
				iter_q <= '0;
			end else if (cmd.step) begin
				iter_q <= iter_q + 1'b1;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.exec && is_push) begin
			out_byte    <= '0;
			is_empty    <= 1'b0;
			overflow    <= full;
			last_of_run <= 1'b1;
		end else if (cmd.exec && empty) begin
			out_byte    <= '0;
			is_empty    <= 1'b1;
			overflow    <= 1'b0;
			last_of_run <= 1'b1;
		end else if (cmd.load_data) begin
			out_byte    <= rdata;
			is_empty    <= 1'b0;
			overflow    <= 1'b0;
			last_of_run <= is_pop || (iter_q == count_m1[IDX_W-1:0]);
		end
	end

	assign status.op_valid = is_push || is_pop || is_dump;
	assign status.is_push  = is_push;
	assign status.empty    = empty;
	assign status.out_last = last_of_run;

	`DEQ_ASSERT(a_count_range, clk, arst_n, count_q <= CNT_W'(DEPTH),
		"entry count beyond depth")
	`DEQ_ASSERT(a_front_range, clk, arst_n, front_q <= IDX_W'(DEPTH - 1),
		"front index beyond depth")
	`DEQ_ASSERT_NEXT(a_push_grows, clk, arst_n, we,
		count_q == CNT_W'($past(count_q) + 1'b1), "push did not grow the count")
	`DEQ_ASSERT_NEXT(a_dump_keeps, clk, arst_n, cmd.exec && is_dump,
		$stable(count_q) && $stable(front_q), "dump changed the queue")

endmodule

`default_nettype wire

### rtl/core/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: takes one input word, runs it through the datapath, hands out
// its result words one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl import deq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  wire logic        out_stall,
	output deq_cmd_t         cmd,
	input  wire deq_status_t status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WAIT,
		S_OUT
	} state_t;

	state_t state_q;

	assign in_stall      = (state_q != S_IDLE);
	assign cmd.latch     = (state_q == S_IDLE) && in_valid;
	assign cmd.exec      = (state_q == S_EXEC);
	assign cmd.load_data = (state_q == S_WAIT);
	assign cmd.step      = (state_q == S_OUT) && !out_stall && !status.out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					// drop unused opcodes; push (status-only) and empty results skip the read
					if (!status.op_valid) begin
						state_q <= S_IDLE;
					end else if (status.is_push || status.empty) begin
						state_q   <= S_OUT;
						out_valid <= 1'b1;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					state_q   <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= status.out_last ? S_IDLE : S_EXEC;
					end
				end
				default: begin
					state_q   <= S_IDLE;
					out_valid <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded byte deque on a ring store, one word in flight.
// Push: result registered as S_EXEC moves to S_OUT. Pop: through S_WAIT (store read port).
// Dump: S_EXEC, S_WAIT, S_OUT per entry, the store being read once per entry by one port.
// Next word taken the cycle after the final result leaves; reset clears
// pointers and count at once, store contents stay undefined, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue import deq_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        opcode,
	input  wire logic [BYTE_W-1:0] push_byte,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [BYTE_W-1:0] out_byte,
	output logic                   is_empty,
	output logic                   overflow,
	output logic                   last_of_run
);

	deq_cmd_t    cmd;
	deq_status_t status;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	deq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.opcode      (opcode),
		.push_byte   (push_byte),
		.out_byte    (out_byte),
		.is_empty    (is_empty),
		.overflow    (overflow),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire
